FILE: sv/contiguous_page_allocator_macros.svh
// Assertion macros shared by the page allocator RTL.
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define CPA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define CPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cpa_pkg.sv
// Shared types and constants of the contiguous page allocator.
`timescale 1ns / 1ps

package cpa_pkg;

  localparam int ADDR_W    = 64;
  localparam int LEN_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 64;

  // Default page count after reset.
  localparam logic [LEN_W-1:0] PAGES_RESET = 11'd1024;

  // Request kinds.
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2,
    ST_ZERO    = 2'd3
  } status_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_BASE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'd1;

endpackage

FILE: sv/cpa_ifs.sv
// Request and response channel interfaces of the page allocator.
`timescale 1ns / 1ps

interface cpa_req_if import cpa_pkg::*;
;
  logic                    valid;
  logic                    ready;
  op_t                     op;
  logic [LEN_W-1:0]        run_length;
  logic [ADDR_W-1:0]       free_address;

  modport source (output valid, output op, output run_length, output free_address,
                  input ready);
  modport sink   (input valid, input op, input run_length, input free_address,
                  output ready);
endinterface

interface cpa_rsp_if import cpa_pkg::*;
;
  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic [ADDR_W-1:0]       alloc_address;

  modport source (output valid, output status, output alloc_address, input ready);
  modport sink   (input valid, input status, input alloc_address, output ready);
endinterface

FILE: sv/cpa_addr_calc.sv
// Registered address arithmetic: free address to page index, page index to address.
`timescale 1ns / 1ps

module cpa_addr_calc import cpa_pkg::*;
#(
  parameter int IW         = 10,
  parameter int CW         = 11,
  parameter int PAGE_SHIFT = 12
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] base,
  input  logic [ADDR_W-1:0] free_address,
  input  logic [CW-1:0]     count,
  input  logic [IW-1:0]     start_idx,
  output logic              free_ok,
  output logic [IW-1:0]     free_idx,
  output logic [ADDR_W-1:0] alloc_address
);

  logic [ADDR_W:0]   diff_ext;
  logic [ADDR_W-1:0] page_off;

  // Offset from the base; the top bit is the borrow of an address below it.
  assign diff_ext = {1'b0, free_address} - {1'b0, base};
  assign page_off = diff_ext[ADDR_W-1:0] >> PAGE_SHIFT;

  // All three results are registered; the controller waits for them.
  always_ff @(posedge clk) begin
    free_ok       <= !diff_ext[ADDR_W] && (page_off < ADDR_W'(count));
    free_idx      <= page_off[IW-1:0];
    alloc_address <= base + (ADDR_W'(start_idx) << PAGE_SHIFT);
  end

endmodule

FILE: sv/contiguous_page_allocator.sv
// Top level of the first-fit contiguous page allocator with its descriptor memory.
//
// Usage: requests arrive on the req channel (op, run_length, free_address) and each
// gives exactly one word on the rsp channel (status, alloc_address). Both channels
// move a word when valid and ready are high at a rising clock edge. The two
// configuration registers (alloc_base, pages_in_use) are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while no request is in
// flight, which the block itself does not enforce. One request is worked at a
// time; the descriptor memory (one registered read port, one write port) sets the
// time. An allocate scans one page per cycle and then marks one page per cycle. A
// free walks one page per cycle. A zero count or a run longer than the page count
// is answered without a scan. After reset the memory is cleared in a pass over all
// NUM_PAGES pages during which req.ready stays low. The result sits in an output
// register: a new request is taken while it waits, and only the finishing step
// waits on a stalled receiver.
`timescale 1ns / 1ps
`include "contiguous_page_allocator_macros.svh"

module contiguous_page_allocator import cpa_pkg::*;
#(
  parameter int NUM_PAGES  = 1024,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  cpa_req_if.sink              req,
  cpa_rsp_if.source            rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CW = $clog2(NUM_PAGES + 1);
  localparam logic [IW-1:0] LAST_PAGE = IW'(NUM_PAGES - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_MARK  = 7'b0001000,
    S_FCHK  = 7'b0010000,
    S_FGO   = 7'b0100000,
    S_WALK  = 7'b1000000
  } state_t;

  // Finishing is tracked by a separate flag so a result can wait for the receiver.
  state_t            state;
  logic              done;
  status_t           status_q;
  op_t               op_q;
  logic [LEN_W-1:0]  len_q;
  logic [ADDR_W-1:0] faddr_q;
  logic [CW-1:0]     n_q;
  logic [CW-1:0]     n_now;
  logic [CW-1:0]     last_idx;

  logic [ADDR_W-1:0] alloc_base;
  logic [LEN_W-1:0]  pages_in_use;

  logic [IW-1:0]     clr_idx;
  logic [IW-1:0]     rd_idx;
  logic [IW-1:0]     chk_idx;
  logic              chk_vld;
  logic [LEN_W-1:0]  run;
  logic [IW-1:0]     fnd_end;
  logic [IW-1:0]     start_q;
  logic [IW-1:0]     wr_idx;
  logic [IW-1:0]     walk_p;

  logic [1:0]        mem [NUM_PAGES];
  logic [1:0]        rd_data;
  logic [IW-1:0]     rd_addr;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [1:0]        mem_wdata;

  logic              pg_taken;
  logic              pg_last;
  logic              out_valid;
  status_t           out_status;
  logic [ADDR_W-1:0] out_addr;
  logic              out_load;
  logic              accept;

  logic              calc_free_ok;
  logic [IW-1:0]     calc_free_idx;
  logic [ADDR_W-1:0] calc_alloc_addr;

  assign pg_taken = rd_data[1];
  assign pg_last  = rd_data[0];
  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && !done;

  // Effective page count saturates at the memory depth.
  assign n_now = (32'(pages_in_use) > NUM_PAGES) ? CW'(NUM_PAGES) : CW'(pages_in_use);
  assign last_idx = n_q - CW'(1);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_base   <= '0;
      pages_in_use <= PAGES_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ALLOC_BASE) begin
        alloc_base <= cfg_data;
      end else if (cfg_index == CFG_PAGES_IN_USE) begin
        pages_in_use <= cfg_data[LEN_W-1:0];
      end
    end
  end

  cpa_addr_calc #(
    .IW         (IW),
    .CW         (CW),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_addr_calc (
    .clk           (clk),
    .base          (alloc_base),
    .free_address  (faddr_q),
    .count         (n_q),
    .start_idx     (start_q),
    .free_ok       (calc_free_ok),
    .free_idx      (calc_free_idx),
    .alloc_address (calc_alloc_addr)
  );

  // Read address: scan pointer, first page of a free, or the next page of a walk.
  always_comb begin
    case (state)
      S_SCAN:  rd_addr = rd_idx;
      S_FGO:   rd_addr = calc_free_idx;
      S_WALK:  rd_addr = (CW'(walk_p) == last_idx) ? walk_p : walk_p + IW'(1);
      default: rd_addr = rd_idx;
    endcase
  end

  // Write port: clearing pass, run marking, and the free walk.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_idx;
    mem_wdata = 2'b00;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, wr_idx == fnd_end};
      end
      S_WALK: begin
        mem_we    = pg_taken || pg_last;
        mem_waddr = walk_p;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Descriptor memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // Main controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      done     <= 1'b0;
      clr_idx  <= '0;
      chk_vld  <= 1'b0;
      status_q <= ST_OK;
    end else begin
      if (out_load) begin
        done <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IW'(1);
          if (clr_idx == LAST_PAGE) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q    <= req.op;
            len_q   <= req.run_length;
            faddr_q <= req.free_address;
            n_q     <= n_now;
            rd_idx  <= '0;
            chk_vld <= 1'b0;
            run     <= '0;
            if (req.op == OP_FREE) begin
              state <= S_FCHK;
            end else if (req.run_length == '0) begin
              status_q <= ST_ZERO;
              done     <= 1'b1;
            end else if (32'(req.run_length) > 32'(n_now)) begin
              status_q <= ST_NOFIT;
              done     <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Reads run one page ahead of the check.
          if (CW'(rd_idx) != last_idx) begin
            rd_idx <= rd_idx + IW'(1);
          end
          chk_idx <= rd_idx;
          chk_vld <= 1'b1;
          if (chk_vld) begin
            if (pg_taken) begin
              run <= '0;
            end else begin
              run <= run + LEN_W'(1);
            end
            if (!pg_taken && (run + LEN_W'(1) == len_q)) begin
              fnd_end <= chk_idx;
              start_q <= IW'(32'(chk_idx) + 32'd1 - 32'(len_q));
              wr_idx  <= IW'(32'(chk_idx) + 32'd1 - 32'(len_q));
              state   <= S_MARK;
            end else if (CW'(chk_idx) == last_idx) begin
              status_q <= ST_NOFIT;
              done     <= 1'b1;
              state    <= S_IDLE;
            end
          end
        end
        S_MARK: begin
          if (wr_idx == fnd_end) begin
            status_q <= ST_OK;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            wr_idx <= wr_idx + IW'(1);
          end
        end
        S_FCHK: begin
          state <= S_FGO;
        end
        S_FGO: begin
          walk_p <= calc_free_idx;
          if (calc_free_ok) begin
            state <= S_WALK;
          end else begin
            status_q <= ST_BADFREE;
            done     <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_WALK: begin
          if (pg_taken && !pg_last) begin
            if (CW'(walk_p) == last_idx) begin
              status_q <= ST_BADFREE;
              done     <= 1'b1;
              state    <= S_IDLE;
            end else begin
              walk_p <= walk_p + IW'(1);
            end
          end else begin
            status_q <= pg_last ? ST_OK : ST_BADFREE;
            done     <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register; a finished result moves in once the previous word has left.
  assign out_load = done && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= status_q;
      out_addr   <= (status_q == ST_OK && op_q == OP_ALLOC) ? calc_alloc_addr : '0;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.alloc_address = out_addr;

  // Checks on the controller.
  `CPA_ASSERT_IMPL(a_write_states, mem_we, (state == S_CLEAR) || (state == S_MARK) || (state == S_WALK), "descriptor write outside clear, mark or walk")
  `CPA_ASSERT_IMPL(a_no_take_in_clear, state == S_CLEAR, !req.ready, "request taken during clearing pass")
  `CPA_ASSERT_NEXT(a_accept_busy, accept, (state != S_IDLE) || done, "accepted request started no work")
  `CPA_ASSERT_IMPL(a_mark_in_run, state == S_MARK, (wr_idx <= fnd_end) && (start_q <= fnd_end), "mark pointer left the found run")

endmodule
